/* rtl/railcom_channel1_address_decoder_assert.svh */
// assertion helpers used by the decoder back end
`ifndef RAILCOM_CHANNEL1_ADDRESS_DECODER_ASSERT_SVH
`define RAILCOM_CHANNEL1_ADDRESS_DECODER_ASSERT_SVH

// same-cycle implication, held off during reset
`define RCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rcd_pkg.sv */
package rcd_pkg;

    localparam int BYTE_W = 8;
    localparam int SYM_W  = 7;
    localparam int HALF_W = 8;
    localparam int ADDR_W = 15;
    localparam int MASK_W = 6;

    // frame and symbol constants
    localparam logic [BYTE_W-1:0] FRAME_MARK  = 8'h00;
    localparam logic [BYTE_W-1:0] RANGE_LO    = 8'h0F;
    localparam logic [BYTE_W-1:0] RANGE_HI    = 8'hF0;
    localparam logic [BYTE_W-1:0] SYM_INVALID = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MASK  = 1'b1;

    localparam logic [MASK_W-1:0] HIGH_MASK_RST = 6'd8;
    localparam logic [MASK_W-1:0] LOW_MASK_RST  = 6'd4;

    // frame queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SYM_W-1:0] first_sym;
        logic [SYM_W-1:0] second_sym;
    } rcd_frame_t;

    typedef struct packed {
        logic [MASK_W-1:0] high_mask;
        logic [MASK_W-1:0] low_mask;
    } rcd_cfg_t;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] sym;
    } rcd_sym_t;

    // 4-of-8 code table, 0xFF marks a byte that is no code
    localparam logic [7:0] SYM_TABLE [256] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd64,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd51,
        8'd255, 8'd255, 8'd255, 8'd52,  8'd255, 8'd53,  8'd54,  8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd58,
        8'd255, 8'd255, 8'd255, 8'd59,  8'd255, 8'd60,  8'd55,  8'd255,
        8'd255, 8'd255, 8'd255, 8'd63,  8'd255, 8'd61,  8'd56,  8'd255,
        8'd255, 8'd62,  8'd57,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd36,
        8'd255, 8'd255, 8'd255, 8'd35,  8'd255, 8'd34,  8'd33,  8'd255,
        8'd255, 8'd255, 8'd255, 8'd31,  8'd255, 8'd30,  8'd32,  8'd255,
        8'd255, 8'd29,  8'd28,  8'd255, 8'd27,  8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd25,  8'd255, 8'd24,  8'd26,  8'd255,
        8'd255, 8'd23,  8'd22,  8'd255, 8'd21,  8'd255, 8'd255, 8'd255,
        8'd255, 8'd37,  8'd20,  8'd255, 8'd19,  8'd255, 8'd255, 8'd255,
        8'd50,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd14,  8'd255, 8'd13,  8'd12,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd10,  8'd255, 8'd9,   8'd11,
        8'd255, 8'd255, 8'd8,   8'd7,   8'd255, 8'd6,   8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd4,   8'd255, 8'd3,   8'd5,
        8'd255, 8'd255, 8'd2,   8'd1,   8'd255, 8'd0,   8'd255, 8'd255,
        8'd255, 8'd255, 8'd15,  8'd16,  8'd255, 8'd17,  8'd255, 8'd255,
        8'd255, 8'd18,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd43,  8'd48,
        8'd255, 8'd255, 8'd42,  8'd47,  8'd255, 8'd49,  8'd255, 8'd255,
        8'd255, 8'd255, 8'd41,  8'd46,  8'd255, 8'd45,  8'd255, 8'd255,
        8'd255, 8'd44,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd66,  8'd40,  8'd255, 8'd39,  8'd255, 8'd255,
        8'd255, 8'd38,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd65,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    // range check plus table lookup
    function automatic rcd_sym_t rcd_decode(input logic [BYTE_W-1:0] b);
        rcd_sym_t   r;
        logic [7:0] t;
        t     = SYM_TABLE[b];
        r.ok  = (b >= RANGE_LO) && (b <= RANGE_HI) && (t != SYM_INVALID);
        r.sym = t[SYM_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/rcd_front.sv */
module rcd_front
    import rcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output rcd_frame_t        q_data
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0] phase_reg, phase_next;
    rcd_sym_t   first_reg, first_next;
    rcd_sym_t   dec;
    logic       accept;

    // hold off bytes while the frame queue is full
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign dec      = rcd_decode(rx_byte);

    // frame phase tracking
    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == FRAME_MARK)
                        phase_next = PH_FIRST;
                end
                PH_FIRST:
                begin
                    first_next = dec.ok ? dec : '0;
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    phase_next = PH_HUNT;
                    q_push     = first_reg.ok && dec.ok;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    assign q_data.first_sym  = first_reg.sym;
    assign q_data.second_sym = dec.sym;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            first_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

/* rtl/rcd_queue.sv */
module rcd_queue
    import rcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rcd_frame_t push_data,
    input  logic       pop,
    output rcd_frame_t pop_data,
    output logic       full,
    output logic       empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rcd_frame_t    slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/rcd_back.sv */
module rcd_back
    import rcd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rcd_cfg_t          cfg,
    input  logic              q_empty,
    input  rcd_frame_t        q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] stable_address
);

`include "railcom_channel1_address_decoder_assert.svh"

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]              state_reg, state_next;
    rcd_frame_t              frame_reg, frame_next;
    logic [HALF_W-1:0]       half_a_reg, half_a_next;
    logic [HALF_W-1:0]       half_b_reg, half_b_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    mismatch_reg, mismatch_next;
    logic [HISTORY_DEPTH-1:0] hist_valid_reg, hist_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]       out_addr_reg, out_addr_next;

    logic [ADDR_W-1:0]       hist_mem [HISTORY_DEPTH];
    logic [ADDR_W-1:0]       rd_data_reg;
    logic                    rd_valid_reg;
    logic [ADDR_W-1:0]       entry;
    logic [HALF_W-1:0]       half_val;
    logic                    hist_we;

    assign out_valid      = out_valid_reg;
    assign stable_address = out_addr_reg;

    // an entry never written reads as zero
    assign entry    = rd_valid_reg ? rd_data_reg : '0;
    assign half_val = {frame_reg.first_sym[1:0], 6'b0} | {1'b0, frame_reg.second_sym};
    assign hist_we  = (state_reg == S_WRITE);

    // frame processing sequencer
    always_comb
    begin
        state_next      = state_reg;
        frame_next      = frame_reg;
        half_a_next     = half_a_reg;
        half_b_next     = half_b_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        mismatch_next   = mismatch_reg;
        hist_valid_next = hist_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_addr_next   = out_addr_reg;
        q_pop           = 1'b0;
        rd_pend_next    = (state_reg == S_SCAN);

        // compare the entry read in the previous cycle
        if (rd_pend_reg && (entry != addr_reg))
            mismatch_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    frame_next = q_data;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if ((frame_reg.first_sym[MASK_W-1:0] & cfg.high_mask) != '0)
                    half_a_next = half_val;
                if ((frame_reg.first_sym[MASK_W-1:0] & cfg.low_mask) != '0)
                    half_b_next = half_val;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                addr_next = half_b_reg[HALF_W-1] ? {half_b_reg[HALF_W-2:0], half_a_reg}
                                                 : {7'b0, half_a_reg};
                hist_valid_next[ptr_reg] = 1'b1;
                ptr_next      = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                idx_next      = '0;
                mismatch_next = 1'b0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_DONE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (mismatch_reg)
                    state_next = S_IDLE;
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = addr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            half_a_reg     <= '0;
            half_b_reg     <= '0;
            ptr_reg        <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            mismatch_reg   <= 1'b0;
            hist_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            half_a_reg     <= half_a_next;
            half_b_reg     <= half_b_next;
            ptr_reg        <= ptr_next;
            idx_reg        <= idx_next;
            rd_pend_reg    <= rd_pend_next;
            mismatch_reg   <= mismatch_next;
            hist_valid_reg <= hist_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        addr_reg     <= addr_next;
        out_addr_reg <= out_addr_next;
    end

    // address history memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[ptr_reg] <= addr_next;
        rd_data_reg  <= hist_mem[idx_reg];
        rd_valid_reg <= hist_valid_reg[idx_reg];
    end

    `RCD_ASSERT_NEXT(a_write_starts_scan, clk, rst_n, state_reg == S_WRITE, (state_reg == S_SCAN) && (idx_reg == '0), "history write not followed by scan from entry zero")
    `RCD_ASSERT_IMPLY(a_read_from_scan, clk, rst_n, rd_pend_reg, $past(state_reg) == S_SCAN, "compare without a scan read")
    `RCD_ASSERT_IMPLY(a_emit_only_uniform, clk, rst_n, $rose(out_valid_reg), ($past(state_reg) == S_EMIT) && !$past(mismatch_reg), "address emitted without a uniform history")
    `RCD_ASSERT_IMPLY(a_pop_when_idle, clk, rst_n, q_pop, (state_reg == S_IDLE) && !q_empty, "frame taken while busy")

endmodule

/* rtl/railcom_channel1_address_decoder.sv */
// Decodes channel-1 address frames: a zero byte starts a frame, the next two
// bytes are 4-of-8 coded symbols, and a valid frame updates those of the two
// kept address halves that the mask registers select. Each new 15-bit
// address goes into a history of HISTORY_DEPTH entries (zero after reset) and
// is put out only when every entry equals it. Bytes are taken at one per
// cycle while the two-frame queue has room. The back end handles one frame
// at a time; its history compare reads one entry per cycle from the history
// memory. An address waits in the output register until taken; the user
// must write the masks only while idle, which the block does not enforce.
module railcom_channel1_address_decoder
    import rcd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    stable_address,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data
);

    rcd_cfg_t   cfg_reg, cfg_next;
    rcd_frame_t push_data, pop_data;
    logic       q_push, q_pop, q_full, q_empty;

    // mask register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HIGH_MASK: cfg_next.high_mask = cfg_data;
                CFG_LOW_MASK:  cfg_next.low_mask  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_mask <= HIGH_MASK_RST;
            cfg_reg.low_mask  <= LOW_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    rcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    rcd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stable_address (stable_address)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rcd_pkg::*;

    localparam int HIST_DEPTH = 4;
    // frame plus the two-frame queue in the back end, with margin
    localparam int DRAIN_CYCLES = 4 * (HIST_DEPTH + 5) + 8;
    localparam int LONG_HOLD_CYCLES = 400;

    // 4-of-8 code byte for each symbol; symbol 65 only has an out-of-range code
    localparam logic [7:0] CODE_OF [67] = '{
        8'hAD, 8'hAB, 8'hAA, 8'hA6, 8'hA4, 8'hA7, 8'h9D, 8'h9B,
        8'h9A, 8'h96, 8'h94, 8'h97, 8'h8F, 8'h8E, 8'h8C, 8'hB2,
        8'hB3, 8'hB5, 8'hB9, 8'h74, 8'h72, 8'h6C, 8'h6A, 8'h69,
        8'h65, 8'h63, 8'h66, 8'h5C, 8'h5A, 8'h59, 8'h55, 8'h53,
        8'h56, 8'h4E, 8'h4D, 8'h4B, 8'h47, 8'h71, 8'hE9, 8'hE5,
        8'hE3, 8'hD2, 8'hCA, 8'hC6, 8'hD9, 8'hD5, 8'hD3, 8'hCB,
        8'hC7, 8'hCD, 8'h78, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E,
        8'h36, 8'h3A, 8'h27, 8'h2B, 8'h2D, 8'h35, 8'h39, 8'h33,
        8'h0F, 8'hF1, 8'hE2
    };

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
    typedef enum logic [1:0] {HUNT, FIRST_BYTE, SECOND_BYTE} frame_phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [ADDR_W-1:0]    stable_address;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;

    // decoder state as the testbench tracks it
    logic [MASK_W-1:0] high_mask = HIGH_MASK_RST;
    logic [MASK_W-1:0] low_mask  = LOW_MASK_RST;
    frame_phase_t      phase     = HUNT;
    logic [SYM_W-1:0]  first_sym = '0;
    logic              first_ok  = 1'b0;
    logic [HALF_W-1:0] half_a    = '0;
    logic [HALF_W-1:0] half_b    = '0;
    logic [ADDR_W-1:0] addr_hist [HIST_DEPTH];
    int                hist_ptr  = 0;

    logic [ADDR_W-1:0] expected_addresses [$];
    int                mismatches  = 0;
    int                frame_bytes = 0;
    int                burst_left  = 0;
    int                gap_max     = 0;
    stall_mode_t       stall_mode  = STALL_NONE;
    int                output_hold_cycles = 0;

    railcom_channel1_address_decoder #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stable_address (stable_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("railcom_channel1_address_decoder regression: fail");
        $finish;
    end

    // symbol of a code byte, -1 if out of range or no code
    function automatic int symbol_of(input logic [7:0] b);
        if (b < RANGE_LO || b > RANGE_HI)
            return -1;
        for (int s = 0; s < 67; s++)
            if (CODE_OF[s] == b)
                return s;
        return -1;
    endfunction

    // advance the frame tracker by one item and queue any stable address
    task automatic predict_rx_byte(input logic [7:0] b);
        int                s;
        logic [HALF_W-1:0] half;
        logic [ADDR_W-1:0] addr;
        bit                uniform;
        case (phase)
            HUNT:
            begin
                if (b == FRAME_MARK)
                    phase = FIRST_BYTE;
            end
            FIRST_BYTE:
            begin
                s = symbol_of(b);
                first_ok = (s >= 0);
                first_sym = first_ok ? SYM_W'(s) : '0;
                phase = SECOND_BYTE;
            end
            default:
            begin
                phase = HUNT;
                s = symbol_of(b);
                if (first_ok && s >= 0)
                begin
                    half = HALF_W'(s) | {first_sym[1:0], 6'b0};
                    if ((first_sym & {1'b0, high_mask}) != 0)
                        half_a = half;
                    if ((first_sym & {1'b0, low_mask}) != 0)
                        half_b = half;
                    addr = half_b[7] ? {half_b[6:0], half_a} : {7'b0, half_a};
                    addr_hist[hist_ptr] = addr;
                    hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
                    uniform = 1'b1;
                    for (int i = 0; i < HIST_DEPTH; i++)
                        if (addr_hist[i] != addr)
                            uniform = 1'b0;
                    if (uniform)
                        expected_addresses.push_back(addr);
                end
            end
        endcase
    endtask

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            predict_rx_byte(rx_byte);
    end

    // output checker
    always @(posedge clk)
    begin : check_output
        logic [ADDR_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_addresses.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual stable_address %h",
                         $time, stable_address);
                mismatches++;
            end
            else
            begin
                want = expected_addresses.pop_front();
                if (stable_address !== want)
                begin
                    $display("%0t: stable_address expected %h actual %h",
                             $time, want, stable_address);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    initial
    begin : receiver
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (output_hold_cycles > 0)
            begin
                hold_left = output_hold_cycles;
                output_hold_cycles = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: out_stall <= ((cyc % 7) < 3);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    default:        out_stall <= 1'b0;
                endcase
            end
        end
    end

    // offer one item, idling between bursts, and return once it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] first, input logic [7:0] second);
        send_byte(FRAME_MARK);
        send_byte(first);
        send_byte(second);
        frame_bytes += 3;
    endtask

    // let all results come out and the back end go quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_addresses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_masks(input logic [MASK_W-1:0] hi, input logic [MASK_W-1:0] lo);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HIGH_MASK;
        cfg_data  <= hi;
        @(posedge clk);
        high_mask = hi;
        cfg_index <= CFG_LOW_MASK;
        cfg_data  <= lo;
        @(posedge clk);
        low_mask = lo;
        cfg_write <= 1'b0;
    endtask

    // mostly repeated frames so the history fills, plus broken frames and noise
    task automatic run_traffic(input int n_items);
        int start;
        int r;
        int reps;
        int f;
        int s;
        start = frame_bytes;
        while (frame_bytes - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                f = $urandom_range(0, 66);
                s = $urandom_range(0, 66);
                reps = $urandom_range(1, 6);
                repeat (reps)
                begin
                    send_frame(CODE_OF[f], CODE_OF[s]);
                    if ($urandom_range(0, 9) == 0)
                        send_byte(8'($urandom_range(1, 255)));
                end
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_frame(8'($urandom), CODE_OF[$urandom_range(0, 66)]);
                else
                    send_frame(CODE_OF[$urandom_range(0, 66)], 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom));
            end
        end
    endtask

    // field extremes and each special case, with reset masks
    task automatic test_directed();
        gap_max = 2;
        stall_mode = STALL_RANDOM;
        // bytes while hunting are ignored
        send_byte(8'hFF);
        send_byte(8'h55);
        // fresh history: address zero comes out at once
        send_frame(CODE_OF[8], CODE_OF[0]);
        // zero inside a frame is an invalid byte, not a new marker
        send_frame(FRAME_MARK, CODE_OF[8]);
        // only one valid frame byte
        send_frame(8'h0F, 8'hF0);
        // both bytes out of range
        send_frame(8'hF1, 8'h0E);
        // both masks hit
        send_frame(CODE_OF[12], CODE_OF[64]);
        // neither mask hits
        send_frame(CODE_OF[1], CODE_OF[64]);
        // high half above 127, then repeated until the history is uniform
        send_frame(CODE_OF[6], CODE_OF[0]);
        send_frame(CODE_OF[6], CODE_OF[0]);
        wait_idle();
    endtask

    task automatic test_mask_extremes();
        logic [MASK_W-1:0] his [4] = '{6'd0, 6'd63, 6'd63, 6'd0};
        logic [MASK_W-1:0] los [4] = '{6'd0, 6'd63, 6'd0, 6'd63};
        for (int i = 0; i < 4; i++)
        begin
            set_masks(his[i], los[i]);
            gap_max = (i % 2 == 0) ? 0 : 6;
            stall_mode = stall_mode_t'(i);
            run_traffic(60);
            wait_idle();
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_long_hold();
        int f;
        int s;
        gap_max = 0;
        stall_mode = STALL_NONE;
        f = $urandom_range(0, 64);
        s = $urandom_range(0, 64);
        output_hold_cycles = LONG_HOLD_CYCLES;
        repeat (20)
            send_frame(CODE_OF[f], CODE_OF[s]);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 6; i++)
        begin
            set_masks(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 15;
            endcase
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            run_traffic(220);
            wait_idle();
        end
    endtask

    // main sequence
    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
            addr_hist[i] = '0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mask_extremes();
        test_long_hold();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0)
            $display("railcom_channel1_address_decoder regression: pass");
        else
            $display("railcom_channel1_address_decoder regression: fail");
        $finish;
    end

endmodule
